FILE: src/bsr_pkg.sv
// Shared types and constants for the Babylonian square root core.
package bsr_pkg;

  // Fixed field widths of the result word
  localparam int ROOT_W       = 33;
  localparam int COUNT_W      = 7;
  localparam int OUT_TDATA_W  = 40;

  // Stop threshold register
  localparam int          THRESH_W     = 32;
  localparam logic [31:0] THRESH_RESET = 32'd66;

  // First-guess factor 0.075 as a ratio
  localparam int ScaleNum = 75;
  localparam int ScaleDen = 1000;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_UPDATE,
    ST_DIFF,
    ST_CHECK,
    ST_FINISH
  } bsr_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // take a new radicand, form first guess
    logic div_init;   // start a step: save guess, set up the divider
    logic div_step;   // one restoring division bit
    logic update;     // average guess and quotient
    logic diff;       // form |next - guess|
    logic latch_cap;  // record whether the limit cut the run short
    logic out_load;   // move the result into the output register
  } bsr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_zero;    // radicand on the input port is zero
    logic more;       // last change still above threshold
    logic at_max;     // step count reached the limit
  } bsr_stat_t;

endpackage

FILE: src/bsr_datapath.sv
// Datapath: first guess, serial divider, averaging, threshold test, result register.
module bsr_datapath #(
  parameter int RADICAND_BITS = 20,
  parameter int FRACTION_BITS = 16,
  parameter int MAX_STEPS     = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [RADICAND_BITS-1:0]         radicand,
  input  logic                             cfg_wr_en,
  input  logic [bsr_pkg::THRESH_W-1:0]     cfg_wr_data,
  input  bsr_pkg::bsr_cmd_t                cmd,
  output bsr_pkg::bsr_stat_t               stat,
  output logic [bsr_pkg::ROOT_W-1:0]       root_value,
  output logic [bsr_pkg::COUNT_W-1:0]      iteration_count,
  output logic                             hit_limit
);

  // Guess width, dividend width, scale width
  localparam int GW = RADICAND_BITS + FRACTION_BITS + 1;
  localparam int NW = RADICAND_BITS + 2 * FRACTION_BITS;
  localparam int SW = FRACTION_BITS - 3;
  localparam int XW = (GW > bsr_pkg::THRESH_W) ? GW : bsr_pkg::THRESH_W;
  localparam int GUESS_SCALE =
    ((bsr_pkg::ScaleNum << FRACTION_BITS) + bsr_pkg::ScaleDen / 2) / bsr_pkg::ScaleDen;
  localparam logic [SW-1:0] SCALE_V = SW'(GUESS_SCALE);

  logic [RADICAND_BITS-1:0]        n_r;
  logic [GW-1:0]                   cur_r;
  logic [GW-1:0]                   prev_r;
  logic [GW-1:0]                   rem_r;
  logic [NW-1:0]                   num_r;
  logic [GW-1:0]                   diff_r;
  logic [bsr_pkg::COUNT_W-1:0]     steps_r;
  logic                            capped_r;
  logic [bsr_pkg::THRESH_W-1:0]    thresh_r;
  logic [bsr_pkg::ROOT_W-1:0]      root_r;
  logic [bsr_pkg::COUNT_W-1:0]     count_r;
  logic                            limit_r;

  logic [RADICAND_BITS+SW-1:0]     prod;
  logic [GW:0]                     trial;
  logic [GW:0]                     trial_sub;
  logic                            q_bit;
  logic [GW-1:0]                   quot;
  logic [GW-1:0]                   avg;
  logic [GW:0]                     d_fwd;

  // First guess: radicand times the scaled 0.075
  assign prod = {{SW{1'b0}}, radicand} * {{RADICAND_BITS{1'b0}}, SCALE_V};

  // One restoring division bit
  assign trial     = {rem_r, num_r[NW-1]};
  assign trial_sub = trial - {1'b0, prev_r};
  assign q_bit     = ~trial_sub[GW];

  // Babylonian average: (guess + quotient) / 2, rounded down
  assign quot = num_r[GW-1:0];
  assign avg  = (prev_r >> 1) + (quot >> 1) + GW'(prev_r[0] & quot[0]);

  // Signed forward difference, sign picks the direction
  assign d_fwd = {1'b0, cur_r} - {1'b0, prev_r};

  // Status to the controller
  assign stat.in_zero = (radicand == '0);
  assign stat.more    = (XW'(diff_r) > XW'(thresh_r));
  assign stat.at_max  = (steps_r == bsr_pkg::COUNT_W'(MAX_STEPS));

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= bsr_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r      <= radicand;
      cur_r    <= GW'(prod);
      steps_r  <= '0;
      capped_r <= 1'b0;
    end
    if (cmd.div_init) begin
      prev_r  <= cur_r;
      rem_r   <= '0;
      num_r   <= {n_r, {(2 * FRACTION_BITS){1'b0}}};
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? trial_sub[GW-1:0] : trial[GW-1:0];
      num_r <= {num_r[NW-2:0], q_bit};
    end
    if (cmd.update) begin
      cur_r <= avg;
    end
    if (cmd.diff) begin
      diff_r <= d_fwd[GW] ? (prev_r - cur_r) : d_fwd[GW-1:0];
    end
    if (cmd.latch_cap) begin
      capped_r <= stat.more;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      root_r  <= bsr_pkg::ROOT_W'(cur_r);
      count_r <= steps_r;
      limit_r <= capped_r;
    end
  end

  assign root_value      = root_r;
  assign iteration_count = count_r;
  assign hit_limit       = limit_r;

endmodule

FILE: src/bsr_ctrl.sv
// Controller: sequences steps and division bits, owns both handshakes.
module bsr_ctrl #(
  parameter int DIV_BITS = 52
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  bsr_pkg::bsr_stat_t stat,
  output bsr_pkg::bsr_cmd_t  cmd
);

  localparam int CW = $clog2(DIV_BITS);

  bsr_pkg::bsr_state_t state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                in_acc;
  logic                out_free;

  assign in_acc   = in_tvalid && (state_r == bsr_pkg::ST_IDLE);
  assign out_free = !out_valid_r || out_tready;

  // State, bit counter and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsr_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      bsr_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_zero ? bsr_pkg::ST_FINISH : bsr_pkg::ST_START;
        end
      end
      bsr_pkg::ST_START: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = CW'(DIV_BITS - 1);
        state_nxt    = bsr_pkg::ST_DIV;
      end
      bsr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = bsr_pkg::ST_UPDATE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      bsr_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = bsr_pkg::ST_DIFF;
      end
      bsr_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = bsr_pkg::ST_CHECK;
      end
      bsr_pkg::ST_CHECK: begin
        if (stat.more && !stat.at_max) begin
          state_nxt = bsr_pkg::ST_START;
        end else begin
          cmd.latch_cap = 1'b1;
          state_nxt     = bsr_pkg::ST_FINISH;
        end
      end
      bsr_pkg::ST_FINISH: begin
        // Wait until the output register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bsr_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == bsr_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

FILE: src/babylonian_square_root_core.sv
// Top level of the Babylonian square root core.
// Takes an unsigned radicand and returns its square root in unsigned fixed
// point with FRACTION_BITS fraction bits, plus the number of Newton steps and
// a flag set when MAX_STEPS ran without the change dropping to the stop
// threshold. A zero radicand returns zero with no steps. Each step runs one
// restoring division of radicand*2^(2*FRACTION_BITS) by the guess, one
// quotient bit per cycle. One word is in work at a time; the next word is
// taken while a finished result waits in the output register. The stop
// threshold is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while idle, as the core itself does not enforce this.
module babylonian_square_root_core #(
  parameter int RADICAND_BITS = 20,
  parameter int FRACTION_BITS = 16,
  parameter int MAX_STEPS     = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // [RADICAND_BITS-1:0] radicand, zero fill above
  input  logic [((RADICAND_BITS+7)/8)*8-1:0]    in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [32:0] root_value, [39:33] iteration_count
  output logic [bsr_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // [0] hit_limit
  output logic                                  out_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_wr_en,
  input  logic [bsr_pkg::THRESH_W-1:0]          cfg_wr_data
);

  localparam int DIV_BITS = RADICAND_BITS + 2 * FRACTION_BITS;

  bsr_pkg::bsr_cmd_t            cmd;
  bsr_pkg::bsr_stat_t           stat;
  logic [bsr_pkg::ROOT_W-1:0]   root_value;
  logic [bsr_pkg::COUNT_W-1:0]  iteration_count;
  logic                         hit_limit;

  bsr_ctrl #(
    .DIV_BITS (DIV_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bsr_datapath #(
    .RADICAND_BITS (RADICAND_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .MAX_STEPS     (MAX_STEPS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .radicand        (in_tdata[RADICAND_BITS-1:0]),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .stat            (stat),
    .root_value      (root_value),
    .iteration_count (iteration_count),
    .hit_limit       (hit_limit)
  );

  // Pack the result word
  assign out_tdata = {iteration_count, root_value};
  assign out_tuser = hit_limit;

endmodule
